// ----- rtl/core/kvl_pkg.sv -----
package kvl_pkg;

    // fixed field widths
    localparam int DATA_W      = 32;
    localparam int SLOT_W      = 6;
    localparam int KEY_COUNT_W = 7;

    // product and quotient of one interpolation step
    localparam int PROD_W      = 2 * DATA_W;
    localparam int STEP_W      = $clog2(PROD_W);
    localparam int QSAT_BIT    = 40;

    localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 7'd1;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // input transaction
    typedef struct packed {
        logic                     opcode;
        logic [SLOT_W-1:0]        key_slot;
        logic [DATA_W-1:0]        key_stamp;
        logic signed [DATA_W-1:0] key_x;
        logic signed [DATA_W-1:0] key_y;
        logic signed [DATA_W-1:0] key_z;
        logic [DATA_W-1:0]        query_stamp;
    } kvl_in_t;

    // output transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     zero_span;
    } kvl_out_t;

    // one stored keyframe
    typedef struct packed {
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
    } kvl_key_t;

    // request to one interpolation unit
    typedef struct packed {
        logic              launch;
        logic [DATA_W-1:0] start_val;
        logic [DATA_W-1:0] end_val;
        logic [DATA_W-1:0] num_mag;
        logic              num_neg;
        logic [DATA_W-1:0] den_mag;
        logic              den_neg;
    } kvl_lerp_req_t;

endpackage

// ----- rtl/core/kvl_ram.sv -----
module kvl_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/core/kvl_lerp.sv -----
module kvl_lerp
    import kvl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  kvl_lerp_req_t            req,
    output logic                     done,
    output logic signed [DATA_W-1:0] result
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } lerp_state_t;

    lerp_state_t              state_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [DATA_W-1:0]        start_reg;
    logic [DATA_W-1:0]        num_reg;
    logic [DATA_W-1:0]        delta_reg;
    logic [DATA_W-1:0]        den_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [PROD_W-1:0]        quot_reg;

    logic signed [DATA_W:0]   delta;
    logic [DATA_W-1:0]        delta_mag;
    logic                     delta_neg;
    logic [DATA_W:0]          rem_shift;
    logic                     rem_ge;
    logic [DATA_W-1:0]        rem_next;
    logic [QSAT_BIT:0]        qmag;
    logic signed [DATA_W+10:0] sum;

    // segment delta and its magnitude
    always_comb
    begin
        delta     = $signed({req.end_val[DATA_W-1], req.end_val})
                  - $signed({req.start_val[DATA_W-1], req.start_val});
        delta_neg = delta[DATA_W];
        delta_mag = delta_neg ? DATA_W'(-delta) : delta[DATA_W-1:0];
    end

    // one restoring division step
    always_comb
    begin
        rem_shift = {rem_reg, prod_reg[PROD_W-1]};
        rem_ge    = rem_shift >= {1'b0, den_reg};
        rem_next  = rem_ge ? DATA_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DATA_W-1:0];
    end

    // clamp quotient, apply sign, saturate
    always_comb
    begin
        qmag = (|quot_reg[PROD_W-1:QSAT_BIT]) ? {1'b1, {QSAT_BIT{1'b0}}}
                                              : quot_reg[QSAT_BIT:0];
        if (neg_reg)
        begin
            sum = $signed({{11{start_reg[DATA_W-1]}}, start_reg}) - $signed({2'b00, qmag});
        end
        else
        begin
            sum = $signed({{11{start_reg[DATA_W-1]}}, start_reg}) + $signed({2'b00, qmag});
        end
        if (sum > 43'sd2147483647)
        begin
            result = 32'sh7FFF_FFFF;
        end
        else if (sum < -43'sd2147483648)
        begin
            result = 32'sh8000_0000;
        end
        else
        begin
            result = sum[DATA_W-1:0];
        end
        done = (state_reg == L_FIN);
    end

    // sequencer: operand capture, multiply, divide, finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (req.launch)
                    begin
                        start_reg <= req.start_val;
                        num_reg   <= req.num_mag;
                        delta_reg <= delta_mag;
                        den_reg   <= req.den_mag;
                        neg_reg   <= req.num_neg ^ req.den_neg ^ delta_neg;
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    prod_reg  <= PROD_W'(num_reg) * PROD_W'(delta_reg);
                    rem_reg   <= '0;
                    quot_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    rem_reg  <= rem_next;
                    quot_reg <= {quot_reg[PROD_W-2:0], rem_ge};
                    prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == {STEP_W{1'b1}})
                    begin
                        state_reg <= L_FIN;
                    end
                end
                L_FIN:
                begin
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    // divisor is never zero while dividing
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == L_DIV |-> den_reg != '0)
        else $error("division with zero divisor");

    // a launch is only honored when idle
    a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.launch |-> state_reg == L_IDLE)
        else $error("launch while busy");

    // division takes a full pass of steps
    a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(state_reg == L_DIV && step_reg == {STEP_W{1'b1}}))
        else $error("finish without full division");

endmodule

// ----- rtl/core/keyframe_vector_lerp.sv -----
// load: key written to the key memory, no result
// query: issue, scan keys with one memory read per key scanned, read the start key,
//   then multiply, divide in 64 steps and finish, and load the output register; at most
//   key_count - 1 keys are scanned; a single key or a zero-length segment skips multiply and divide
// one transaction at a time; the output register lets a new one in while a result waits
// reset clears control and sets key_count to 1; key memory contents undefined until loaded
module keyframe_vector_lerp
    import kvl_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [KEY_COUNT_W-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  kvl_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output kvl_out_t               out_data
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int KW = $bits(kvl_key_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_SCAN,
        S_FIRST,
        S_LERP,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     last_idx_reg;
    logic [AW-1:0]     last_idx_next;
    logic [AW-1:0]     idx_reg;
    logic [DATA_W-1:0] query_reg;
    kvl_key_t          end_key_reg;
    kvl_out_t          res_reg;
    logic              out_valid_reg;
    kvl_out_t          out_data_reg;

    logic              accept;
    logic              slot_ok;
    logic              hit;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    kvl_key_t          ram_wdata;
    logic [KW-1:0]     ram_rdata;
    kvl_key_t          rd_key;

    logic [DATA_W:0]   num;
    logic [DATA_W:0]   den;
    logic              num_neg;
    logic              den_neg;
    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic              launch;
    kvl_lerp_req_t     req_x;
    kvl_lerp_req_t     req_y;
    kvl_lerp_req_t     req_z;
    logic              done_x;
    logic              done_y;
    logic              done_z;
    logic signed [DATA_W-1:0] res_x;
    logic signed [DATA_W-1:0] res_y;
    logic signed [DATA_W-1:0] res_z;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // clamp key count to 1..MAX_KEYS and keep the last index
    always_comb
    begin
        if (cfg_data == '0)
        begin
            last_idx_next = '0;
        end
        else if (int'(cfg_data) > MAX_KEYS)
        begin
            last_idx_next = AW'(MAX_KEYS - 1);
        end
        else
        begin
            last_idx_next = AW'(int'(cfg_data) - 1);
        end
    end

    // key memory access
    assign rd_key  = kvl_key_t'(ram_rdata);
    assign slot_ok = int'(in_data.key_slot) < MAX_KEYS;
    assign hit     = (rd_key.stamp > query_reg) || (idx_reg == last_idx_reg);

    always_comb
    begin
        ram_we          = accept && (in_data.opcode == OP_LOAD) && slot_ok;
        ram_wdata.stamp = in_data.key_stamp;
        ram_wdata.x     = in_data.key_x;
        ram_wdata.y     = in_data.key_y;
        ram_wdata.z     = in_data.key_z;
        ram_addr        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_data.opcode == OP_LOAD)
                begin
                    ram_addr = AW'(in_data.key_slot);
                end
                else if (last_idx_reg != '0)
                begin
                    ram_addr = AW'(1);
                end
            end
            S_SCAN:
            begin
                ram_addr = hit ? AW'(idx_reg - 1'b1) : AW'(idx_reg + 1'b1);
            end
            default:
            begin
                ram_addr = '0;
            end
        endcase
    end

    kvl_ram #(
        .WIDTH (KW),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // segment offset and length, start key on the read port
    always_comb
    begin
        num     = {1'b0, query_reg} - {1'b0, rd_key.stamp};
        den     = {1'b0, end_key_reg.stamp} - {1'b0, rd_key.stamp};
        num_neg = num[DATA_W];
        den_neg = den[DATA_W];
        num_mag = num_neg ? DATA_W'(-num) : num[DATA_W-1:0];
        den_mag = den_neg ? DATA_W'(-den) : den[DATA_W-1:0];
        launch  = (state_reg == S_FIRST) && (den != '0);
    end

    // per-component interpolation requests
    always_comb
    begin
        req_x = '{launch, rd_key.x, end_key_reg.x, num_mag, num_neg, den_mag, den_neg};
        req_y = '{launch, rd_key.y, end_key_reg.y, num_mag, num_neg, den_mag, den_neg};
        req_z = '{launch, rd_key.z, end_key_reg.z, num_mag, num_neg, den_mag, den_neg};
    end

    kvl_lerp u_lerp_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_x),
        .done   (done_x),
        .result (res_x)
    );

    kvl_lerp u_lerp_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_y),
        .done   (done_y),
        .result (res_y)
    );

    kvl_lerp u_lerp_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_z),
        .done   (done_z),
        .result (res_z)
    );

    // query sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_idx_reg  <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                last_idx_reg <= last_idx_next;
            end

            // drain the output register unless a new result replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (in_data.opcode == OP_QUERY))
                    begin
                        query_reg <= in_data.query_stamp;
                        idx_reg   <= AW'(1);
                        state_reg <= (last_idx_reg == '0) ? S_ONE : S_SCAN;
                    end
                end
                S_ONE:
                begin
                    res_reg   <= '{rd_key.x, rd_key.y, rd_key.z, 1'b0};
                    state_reg <= S_DONE;
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        end_key_reg <= rd_key;
                        state_reg   <= S_FIRST;
                    end
                    else
                    begin
                        idx_reg <= AW'(idx_reg + 1'b1);
                    end
                end
                S_FIRST:
                begin
                    if (den == '0)
                    begin
                        res_reg   <= '{rd_key.x, rd_key.y, rd_key.z, 1'b1};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_LERP;
                    end
                end
                S_LERP:
                begin
                    if (done_x)
                    begin
                        res_reg   <= '{res_x, res_y, res_z, 1'b0};
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_data_reg  <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // scan index stays within the keys in use
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> (idx_reg != '0) && (idx_reg <= last_idx_reg))
        else $error("scan index out of range");

    // the three components finish together
    a_lerp_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (done_x == done_y) && (done_y == done_z))
        else $error("interpolation units out of step");

    // interpolation completes only for a running query
    a_done_in_lerp: assert property (@(posedge clk) disable iff (!rst_n)
        done_x |-> state_reg == S_LERP)
        else $error("unexpected interpolation result");

    // a new result only comes from the finishing state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result without finished query");

endmodule

// ----- test/tb_keyframe_vector_lerp.sv -----
`timescale 1ns / 100ps

module tb_keyframe_vector_lerp;
    import kvl_pkg::*;

    localparam int TRACK_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 850;
    localparam int QUERY_LATENCY = 160;
    localparam int DRAIN_LIMIT   = 20000;

    localparam logic [DATA_W-1:0] AXIS_TOP    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] AXIS_BOTTOM = 32'h8000_0000;
    localparam longint            SAT_HIGH    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint            SAT_LOW     = -64'sh0000_0000_8000_0000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [KEY_COUNT_W-1:0] cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    kvl_in_t                in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    kvl_out_t               out_data;

    // predictor copy of the track and the key count
    logic [DATA_W-1:0]      track_stamp [TRACK_DEPTH];
    logic [DATA_W-1:0]      track_x     [TRACK_DEPTH];
    logic [DATA_W-1:0]      track_y     [TRACK_DEPTH];
    logic [DATA_W-1:0]      track_z     [TRACK_DEPTH];
    logic [KEY_COUNT_W-1:0] key_count_cfg = KEY_COUNT_RESET;

    kvl_in_t  track_ops[$];
    kvl_out_t expected_vectors[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // time span of the track the generator last built
    logic [DATA_W-1:0] plan_first;
    logic [DATA_W-1:0] plan_last;

    keyframe_vector_lerp #(
        .MAX_KEYS (TRACK_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void flag_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", what);
    endfunction

    // start + trunc(pos * (to - from) / len), saturated to 32 bits
    function automatic logic [DATA_W-1:0] lerp_axis(input logic [DATA_W-1:0] from_val,
                                                    input logic [DATA_W-1:0] to_val,
                                                    input longint span_pos,
                                                    input longint span_len);
        longint       from_s;
        longint       to_s;
        longint       delta;
        longint       result;
        logic [63:0]  pos_mag;
        logic [63:0]  delta_mag;
        logic [63:0]  len_mag;
        logic [63:0]  step_mag;
        logic [127:0] product;
        logic [127:0] quotient;
        bit           negative;
        from_s    = $signed(from_val);
        to_s      = $signed(to_val);
        delta     = to_s - from_s;
        negative  = ((span_pos < 0) != (delta < 0)) != (span_len < 0);
        pos_mag   = (span_pos < 0) ? -span_pos : span_pos;
        delta_mag = (delta < 0) ? -delta : delta;
        len_mag   = (span_len < 0) ? -span_len : span_len;
        product   = {64'd0, pos_mag} * {64'd0, delta_mag};
        quotient  = product / {64'd0, len_mag};
        // anything this large saturates anyway
        step_mag  = (quotient >= (128'd1 << 40)) ? (64'd1 << 40) : quotient[63:0];
        result    = negative ? from_s - $signed(step_mag) : from_s + $signed(step_mag);
        if (result > SAT_HIGH)
            result = SAT_HIGH;
        if (result < SAT_LOW)
            result = SAT_LOW;
        return result[DATA_W-1:0];
    endfunction

    // vector expected for a query at the given time
    function automatic kvl_out_t predict_query(input logic [DATA_W-1:0] at_stamp);
        kvl_out_t vec;
        int       n_keys;
        int       seg;
        int       i;
        longint   t_from;
        longint   t_to;
        longint   t_at;
        vec    = '0;
        n_keys = key_count_cfg;
        if (n_keys < 1)
            n_keys = 1;
        if (n_keys > TRACK_DEPTH)
            n_keys = TRACK_DEPTH;
        if (n_keys == 1)
        begin
            vec.out_x = track_x[0];
            vec.out_y = track_y[0];
            vec.out_z = track_z[0];
            return vec;
        end
        // first key later than the query, else the final segment
        seg = n_keys - 2;
        for (i = 0; i + 1 < n_keys; i++)
        begin
            if (at_stamp < track_stamp[i + 1])
            begin
                seg = i;
                break;
            end
        end
        t_from = track_stamp[seg];
        t_to   = track_stamp[seg + 1];
        t_at   = at_stamp;
        if (t_to == t_from)
        begin
            vec.out_x     = track_x[seg];
            vec.out_y     = track_y[seg];
            vec.out_z     = track_z[seg];
            vec.zero_span = 1'b1;
            return vec;
        end
        vec.out_x = lerp_axis(track_x[seg], track_x[seg + 1], t_at - t_from, t_to - t_from);
        vec.out_y = lerp_axis(track_y[seg], track_y[seg + 1], t_at - t_from, t_to - t_from);
        vec.out_z = lerp_axis(track_z[seg], track_z[seg + 1], t_at - t_from, t_to - t_from);
        return vec;
    endfunction

    // update the track or queue the expected vector for one accepted transaction
    function automatic void accept_item(input kvl_in_t item);
        if (item.opcode == OP_LOAD)
        begin
            track_stamp[item.key_slot] = item.key_stamp;
            track_x[item.key_slot]     = item.key_x;
            track_y[item.key_slot]     = item.key_y;
            track_z[item.key_slot]     = item.key_z;
        end
        else
        begin
            expected_vectors.push_back(predict_query(item.query_stamp));
        end
    endfunction

    function automatic void check_vector(input kvl_out_t got);
        kvl_out_t want;
        if (expected_vectors.size() == 0)
        begin
            flag_failure($sformatf("unexpected result x=%h y=%h z=%h zero_span=%b",
                                   got.out_x, got.out_y, got.out_z, got.zero_span));
            return;
        end
        want = expected_vectors.pop_front();
        if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
            got.out_z !== want.out_z || got.zero_span !== want.zero_span)
            flag_failure($sformatf(
                "mismatch: expected x=%h y=%h z=%h zero_span=%b, got x=%h y=%h z=%h zero_span=%b",
                want.out_x, want.out_y, want.out_z, want.zero_span,
                got.out_x, got.out_y, got.out_z, got.zero_span));
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                accept_item(in_data);
            if (!in_valid || !in_stall)
            begin
                if (track_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= track_ops.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_vector(out_data);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void set_idle_mode(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 55;
            end
            1:
            begin
                send_idle_pct  = 55;
                recv_stall_pct = 25;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_axis();
        case ($urandom_range(7))
            0:       return AXIS_TOP;
            1:       return AXIS_BOTTOM;
            2:       return '0;
            3, 4:    return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_load(input logic [SLOT_W-1:0] slot,
                                       input logic [DATA_W-1:0] stamp,
                                       input logic [DATA_W-1:0] x,
                                       input logic [DATA_W-1:0] y,
                                       input logic [DATA_W-1:0] z);
        kvl_in_t item;
        item.opcode      = OP_LOAD;
        item.key_slot    = slot;
        item.key_stamp   = stamp;
        item.key_x       = x;
        item.key_y       = y;
        item.key_z       = z;
        item.query_stamp = $urandom;
        track_ops.push_back(item);
    endfunction

    function automatic void queue_query(input logic [DATA_W-1:0] stamp);
        kvl_in_t item;
        item.opcode      = OP_QUERY;
        item.key_slot    = SLOT_W'($urandom);
        item.key_stamp   = $urandom;
        item.key_x       = $urandom;
        item.key_y       = $urandom;
        item.key_z       = $urandom;
        item.query_stamp = stamp;
        track_ops.push_back(item);
    endfunction

    // ascending track in slots 0..n_keys-1, with some repeated times
    function automatic void queue_track(input int n_keys);
        logic [32:0]       stamp_acc;
        logic [DATA_W-1:0] stride;
        int                k;
        case ($urandom_range(3))
            0:       stamp_acc = '0;
            1:       stamp_acc = {1'b0, 32'hFFF0_0000 + $urandom_range(32'h000F_0000)};
            default: stamp_acc = {1'b0, $urandom >> $urandom_range(31, 4)};
        endcase
        for (k = 0; k < n_keys; k++)
        begin
            if (k > 0)
            begin
                case ($urandom_range(9))
                    0:       stride = '0;
                    1, 2:    stride = $urandom_range(255, 1);
                    9:       stride = $urandom >> $urandom_range(12, 0);
                    default: stride = $urandom_range(32'h0004_0000, 1);
                endcase
                stamp_acc = stamp_acc + stride;
                if (stamp_acc[32])
                    stamp_acc = 33'h0_FFFF_FFFF;
            end
            if (k == 0)
                plan_first = stamp_acc[31:0];
            queue_load(SLOT_W'(k), stamp_acc[31:0], rand_axis(), rand_axis(), rand_axis());
        end
        plan_last = stamp_acc[31:0];
    endfunction

    // query time mostly inside the planned track, sometimes outside it
    function automatic logic [DATA_W-1:0] pick_query_stamp();
        logic [63:0] width;
        width = {32'd0, plan_last} - {32'd0, plan_first} + 64'd1;
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return plan_first - $urandom_range(32'h0001_0000);
            2:       return plan_last + $urandom_range(32'h0001_0000);
            3:       return $urandom_range(1) ? plan_first : plan_last;
            default: return plan_first + 32'({32'd0, $urandom} % width);
        endcase
    endfunction

    // wait until the block is idle
    task automatic settle();
        int waited;
        while (track_ops.size() != 0 || in_valid)
            @(negedge clk);
        waited = 0;
        while (expected_vectors.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_vectors.size() != 0)
        begin
            flag_failure($sformatf("%0d results never arrived", expected_vectors.size()));
            expected_vectors.delete();
        end
        repeat (QUERY_LATENCY) @(negedge clk);
    endtask

    task automatic write_key_count(input logic [KEY_COUNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        key_count_cfg  = value;
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        int                     k;
        int                     n_keys;
        int                     n_queries;
        int                     random_items;
        int                     phase_idx;
        logic [KEY_COUNT_W-1:0] count_val;

        set_idle_mode(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // load every slot first so no query ever reads an unloaded key
        for (k = 0; k < TRACK_DEPTH; k++)
            queue_load(SLOT_W'(k), DATA_W'(k << 16), rand_axis(), rand_axis(), rand_axis());

        // single key with extreme values
        queue_load(0, '1, AXIS_TOP, AXIS_BOTTOM, '0);
        queue_query('0);
        queue_query('1);
        settle();

        // key count zero behaves as one key
        write_key_count(7'd0);
        queue_query(32'h0000_0005);
        settle();

        // two keys: zero-length segment, interpolation, extrapolation, unsorted
        write_key_count(7'd2);
        queue_load(0, 32'h0000_1000, '0, AXIS_BOTTOM, AXIS_TOP);
        queue_load(1, 32'h0000_1000, AXIS_TOP, AXIS_TOP, AXIS_BOTTOM);
        queue_query(32'h0000_1000);
        queue_load(1, 32'h0000_2000, AXIS_TOP, AXIS_TOP, AXIS_BOTTOM);
        queue_query(32'h0000_1800);
        queue_query('0);
        queue_query('1);
        queue_load(1, '0, AXIS_TOP, AXIS_TOP, AXIS_BOTTOM);
        queue_query(32'h0000_0800);
        queue_query('1);
        settle();

        // key count above the track depth uses all keys
        write_key_count(7'd127);
        queue_query(32'h003F_8000);
        queue_query('1);
        queue_query(32'h0002_5000);
        settle();

        // random tracks under a range of key counts
        random_items = 0;
        phase_idx    = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            set_idle_mode(random_items * 3 / RANDOM_ITEMS);
            case (phase_idx % 8)
                0:       count_val = 7'd64;
                1:       count_val = KEY_COUNT_W'($urandom_range(127, 65));
                2:       count_val = 7'd0;
                3:       count_val = 7'd1;
                4:       count_val = KEY_COUNT_W'($urandom_range(64, 9));
                default: count_val = KEY_COUNT_W'($urandom_range(8, 2));
            endcase
            write_key_count(count_val);
            if (count_val == 0)
                n_keys = 1;
            else if (count_val > TRACK_DEPTH)
                n_keys = TRACK_DEPTH;
            else
                n_keys = count_val;
            queue_track(n_keys);
            n_queries = $urandom_range(30, 10);
            for (k = 0; k < n_queries; k++)
            begin
                // occasional stray load that may break the ordering
                if ($urandom_range(9) == 0)
                    queue_load(SLOT_W'($urandom_range(TRACK_DEPTH - 1)), $urandom,
                               rand_axis(), rand_axis(), rand_axis());
                else
                    queue_query(pick_query_stamp());
            end
            random_items += n_keys + n_queries;
            phase_idx++;
            settle();
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/kvl_pkg.sv
rtl/core/kvl_ram.sv
rtl/core/kvl_lerp.sv
rtl/core/keyframe_vector_lerp.sv
test/tb_keyframe_vector_lerp.sv
